FILE: hw/rtl/lumaeq_pkg.sv
// shared types and codes for the luma equalization remap block
package lumaeq_pkg;

  typedef enum logic {
    REQ_LOAD  = 1'b0,
    REQ_PIXEL = 1'b1
  } req_t;

  localparam int unsigned ChanW = 8;

  // control that travels alongside one beat through the front end
  typedef struct packed {
    logic             vld;
    logic             pix;
    logic [ChanW-1:0] waddr;
    logic [ChanW-1:0] wdata;
  } ctl_t;

endpackage

FILE: hw/rtl/lumaeq_front.sv
// rgb to ycbcr front end: registered coefficient products, luma index and chroma offsets
module lumaeq_front
  import lumaeq_pkg::*;
#(
  parameter int unsigned COEF_FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  ctl_t                               ctl_in,
  input  logic [ChanW-1:0]                   red,
  input  logic [ChanW-1:0]                   green,
  input  logic [ChanW-1:0]                   blue,
  output ctl_t                               ctl_out,
  output logic [ChanW-1:0]                   luma_idx,
  output logic signed [COEF_FRAC_BITS+10:0]  dcb,
  output logic signed [COEF_FRAC_BITS+10:0]  dcr
);

  localparam int unsigned F   = COEF_FRAC_BITS;
  localparam int unsigned CW  = F + 1;
  localparam int unsigned PW  = CW + ChanW;
  localparam int unsigned YSW = PW + 2;
  localparam int unsigned DW  = F + 11;
  localparam longint unsigned One = 64'd1 << F;

  localparam logic [CW-1:0] KR    = CW'((64'd299 * One + 64'd500) / 64'd1000);
  localparam logic [CW-1:0] KG    = CW'((64'd587 * One + 64'd500) / 64'd1000);
  localparam logic [CW-1:0] KB    = CW'((64'd114 * One + 64'd500) / 64'd1000);
  localparam logic [CW-1:0] KCB_R = CW'((64'd168736 * One + 64'd500000) / 64'd1000000);
  localparam logic [CW-1:0] KCB_G = CW'((64'd331264 * One + 64'd500000) / 64'd1000000);
  localparam logic [CW-1:0] KCR_G = CW'((64'd418688 * One + 64'd500000) / 64'd1000000);
  localparam logic [CW-1:0] KCR_B = CW'((64'd81312 * One + 64'd500000) / 64'd1000000);
  localparam logic [CW-1:0] HALF  = CW'((64'd1 * One + 64'd1) / 64'd2);

  ctl_t ctl_r;
  logic [PW-1:0] p_kr_r, p_kg_r, p_kb_r;
  logic [PW-1:0] p_cbr_r, p_cbg_r, p_cbb_r;
  logic [PW-1:0] p_crr_r, p_crg_r, p_crb_r;
  logic [YSW-1:0] ys;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.vld <= 1'b0;
    end else if (en) begin
      ctl_r       <= ctl_in;
      p_kr_r      <= PW'(KR) * PW'(red);
      p_kg_r      <= PW'(KG) * PW'(green);
      p_kb_r      <= PW'(KB) * PW'(blue);
      p_cbr_r     <= PW'(KCB_R) * PW'(red);
      p_cbg_r     <= PW'(KCB_G) * PW'(green);
      p_cbb_r     <= PW'(HALF) * PW'(blue);
      p_crr_r     <= PW'(HALF) * PW'(red);
      p_crg_r     <= PW'(KCR_G) * PW'(green);
      p_crb_r     <= PW'(KCR_B) * PW'(blue);
    end
  end

  always_comb begin
    ys = YSW'(p_kr_r) + YSW'(p_kg_r) + YSW'(p_kb_r);
    // rounded coefficients can push luma just past the top code
    if (|ys[YSW-1:F+ChanW]) begin
      luma_idx = {ChanW{1'b1}};
    end else begin
      luma_idx = ys[F +: ChanW];
    end
    dcb = $signed(DW'(p_cbb_r)) - $signed(DW'(p_cbr_r)) - $signed(DW'(p_cbg_r));
    dcr = $signed(DW'(p_crr_r)) - $signed(DW'(p_crg_r)) - $signed(DW'(p_crb_r));
  end

  assign ctl_out = ctl_r;

endmodule

FILE: hw/rtl/luma_equalization_remap_core.sv
// top level of the luma equalization remap block: remap table, back conversion, output
// Each beat is either a table load (tuser = 0) or a pixel (tuser = 1). One beat is taken
// every clock while the output side keeps up; a pixel's result passes the front-end
// registers, the table read, the back-conversion products and the output register, and a
// load leaves nothing. The rate is set by the 256 x 8 remap table, which serves one load
// write or one pixel read per cycle; loads reach the table at the same stage as pixel
// reads, so beats see the table in arrival order. All 256 entries must be loaded before
// the first pixel; there is no clearing pass after reset. out_tready low with a result
// waiting stalls the whole pipeline and drops in_tready.
module luma_equalization_remap_core
  import lumaeq_pkg::*;
#(
  parameter int unsigned COEF_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // entry_index, entry_value, red_in, green_in, blue_in
  input  logic [39:0] in_tdata,
  // req_type
  input  logic [0:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // red_out, green_out, blue_out
  output logic [23:0] out_tdata
);

  localparam int unsigned F     = COEF_FRAC_BITS;
  localparam int unsigned CW    = F + 1;
  localparam int unsigned DW    = F + 11;
  localparam int unsigned PRW   = CW + 1 + DW;
  localparam int unsigned SW    = PRW + 1;
  localparam int unsigned HW    = SW - 2 * F;
  localparam int unsigned TW    = HW + 1;
  localparam int unsigned Depth = 256;
  localparam longint unsigned One = 64'd1 << F;

  localparam logic [CW-1:0] KRV = CW'((64'd1402 * One + 64'd500) / 64'd1000);
  localparam logic [CW-1:0] KGU = CW'((64'd344136 * One + 64'd500000) / 64'd1000000);
  localparam logic [CW-1:0] KGV = CW'((64'd714136 * One + 64'd500000) / 64'd1000000);
  localparam logic [CW-1:0] KBU = CW'((64'd1772 * One + 64'd500) / 64'd1000);

  logic advance;
  ctl_t in_ctl;
  ctl_t f_ctl;
  logic [ChanW-1:0] f_idx;
  logic signed [DW-1:0] f_dcb, f_dcr;

  logic [ChanW-1:0] remap_mem [Depth];
  logic [ChanW-1:0] yeq_s2_r;
  logic s2_vld_r;
  logic signed [DW-1:0] dcb_s2_r, dcr_s2_r;

  logic s3_vld_r;
  logic [ChanW-1:0] yeq_s3_r;
  logic signed [PRW-1:0] prv_r, pgu_r, pgv_r, pbu_r;

  logic out_valid_r;
  logic [23:0] out_data_r;
  logic [23:0] out_data_nxt;

  logic signed [SW-1:0] sum_r, sum_g, sum_b;
  logic signed [TW-1:0] t_r, t_g, t_b;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = advance;

  always_comb begin
    in_ctl.vld   = in_tvalid;
    in_ctl.pix   = (req_t'(in_tuser[0]) == REQ_PIXEL);
    in_ctl.waddr = in_tdata[7:0];
    in_ctl.wdata = in_tdata[15:8];
  end

  lumaeq_front #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (advance),
    .ctl_in   (in_ctl),
    .red      (in_tdata[23:16]),
    .green    (in_tdata[31:24]),
    .blue     (in_tdata[39:32]),
    .ctl_out  (f_ctl),
    .luma_idx (f_idx),
    .dcb      (f_dcb),
    .dcr      (f_dcr)
  );

  // table write and read share one stage, so a later load never overtakes an earlier pixel
  always_ff @(posedge clk) begin
    if (advance && f_ctl.vld && !f_ctl.pix) begin
      remap_mem[f_ctl.waddr] <= f_ctl.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && f_ctl.vld && f_ctl.pix) begin
      yeq_s2_r <= remap_mem[f_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s2_vld_r    <= f_ctl.vld && f_ctl.pix;
      s3_vld_r    <= s2_vld_r;
      out_valid_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      dcb_s2_r   <= f_dcb;
      dcr_s2_r   <= f_dcr;
      yeq_s3_r   <= yeq_s2_r;
      prv_r      <= $signed({1'b0, KRV}) * dcr_s2_r;
      pgu_r      <= $signed({1'b0, KGU}) * dcb_s2_r;
      pgv_r      <= $signed({1'b0, KGV}) * dcr_s2_r;
      pbu_r      <= $signed({1'b0, KBU}) * dcb_s2_r;
      out_data_r <= out_data_nxt;
    end
  end

  // the equalized luma is a whole number, so the floor only applies to the chroma terms
  always_comb begin
    sum_r = SW'(prv_r);
    sum_g = -SW'(pgu_r) - SW'(pgv_r);
    sum_b = SW'(pbu_r);
    t_r   = $signed(TW'(yeq_s3_r)) + TW'($signed(sum_r[SW-1:2*F]));
    t_g   = $signed(TW'(yeq_s3_r)) + TW'($signed(sum_g[SW-1:2*F]));
    t_b   = $signed(TW'(yeq_s3_r)) + TW'($signed(sum_b[SW-1:2*F]));
    out_data_nxt[7:0]   = t_r[TW-1] ? 8'd0 : (|t_r[TW-2:ChanW] ? 8'hFF : t_r[7:0]);
    out_data_nxt[15:8]  = t_g[TW-1] ? 8'd0 : (|t_g[TW-2:ChanW] ? 8'hFF : t_g[7:0]);
    out_data_nxt[23:16] = t_b[TW-1] ? 8'd0 : (|t_b[TW-2:ChanW] ? 8'hFF : t_b[7:0]);
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_ready_only_on_full_output: assert property (
    @(posedge clk) disable iff (!rst_n) !in_tready |-> out_valid_r
  ) else $error("input stalled with no result waiting");

  a_stall_freezes_pipeline: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> ($stable(s3_vld_r) && $stable(s2_vld_r)
                                      && $stable(yeq_s3_r) && $stable(prv_r))
  ) else $error("pipeline moved while the output was stalled");

  a_result_from_pixel: assert property (
    @(posedge clk) disable iff (!rst_n) $rose(out_valid_r) |-> $past(s3_vld_r)
  ) else $error("result appeared without a pixel behind it");

  a_load_gives_no_pixel: assert property (
    @(posedge clk) disable iff (!rst_n)
    (advance && f_ctl.vld && !f_ctl.pix) |=> !s2_vld_r
  ) else $error("table load turned into a pixel");

endmodule
